>>> hw/rtl/dssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_pkg: shared types and constants for the dual stack memory unit
// Action and status codes, default sizes, control/status bundles.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CAP_DEF   = 48;
  localparam int WORD_W    = 32;

  typedef enum logic [1:0] {
    ACT_PUSH_LO = 2'd0,
    ACT_PUSH_HI = 2'd1,
    ACT_POP_LO  = 2'd2,
    ACT_POP_HI  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch the request
    logic commit;       // check, update pointers, access memory
    logic load_result;  // move result into the output register
  } dssm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;    // output register empty or draining this cycle
    logic res_refused;  // last committed request was refused
  } dssm_sts_t;

endpackage

>>> hw/rtl/dssm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_req_if: request channel
// Valid/ready channel carrying one push or pop request.
// ----------------------------------------------------------------------------
interface dssm_req_if;
  import dssm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

>>> hw/rtl/dssm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_rsp_if: response channel
// Valid/ready channel carrying the popped word and a status code.
// ----------------------------------------------------------------------------
interface dssm_rsp_if;
  import dssm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pop_value;
  logic [1:0]               status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

>>> hw/rtl/dssm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_ctrl: request sequencer
// Walks each request through capture, commit and result hand-off.
// ----------------------------------------------------------------------------
module dssm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dssm_pkg::dssm_sts_t sts,
  output dssm_pkg::dssm_cmd_t cmd
);
  import dssm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (sts.slot_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("ready raised outside idle");

  a_accept_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.commit && !in_ready_r)
    else $error("captured request not committed next cycle");

endmodule

>>> hw/rtl/dssm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_dp: stack datapath
// Shared word memory, the two stack pointers, limit checks, result register.
// ----------------------------------------------------------------------------
module dssm_dp #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF,
  parameter int CAP   = dssm_pkg::CAP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dssm_pkg::dssm_cmd_t              cmd,
  output dssm_pkg::dssm_sts_t              sts,
  input  logic [1:0]                       in_action,
  input  logic signed [dssm_pkg::WORD_W-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dssm_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                       out_status
);
  import dssm_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int PW   = AW + 1;                 // signed, spans -1 .. DEPTH-1
  localparam int CBW  = $clog2(CAP + 1) + 1;
  localparam int CW   = ((PW > CBW) ? PW : CBW) + 1;
  localparam logic signed [CW-1:0] CAP_X    = CW'(CAP);
  localparam logic signed [CW-1:0] TOP_X    = CW'(DEPTH - 1);
  localparam logic signed [PW-1:0] UP_RESET = PW'(DEPTH - 1);

  logic [WORD_W-1:0] mem [DEPTH];

  action_t                  act_r;
  logic signed [WORD_W-1:0] val_r;
  logic signed [PW-1:0]     lower_top_r, lower_top_nxt;
  logic signed [PW-1:0]     upper_top_r, upper_top_nxt;
  logic signed [PW-1:0]     lo_dec, up_inc;
  logic signed [CW-1:0]     lo_x, up_x, up_cnt;
  logic                     lo_full, up_full, lo_empty, up_empty;
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  status_t                  status_nxt;
  status_t                  res_status_r;
  logic                     res_pop_r;
  logic [WORD_W-1:0]        rd_data_r;
  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_pop_value_r;
  logic [1:0]               out_status_r;

  // limit checks on sign-extended pointers
  assign lo_x     = CW'(lower_top_r);
  assign up_x     = CW'(upper_top_r);
  assign up_cnt   = TOP_X - up_x;
  assign lo_full  = (lo_x >= up_x) || (lo_x >= CAP_X);
  assign up_full  = (up_x < lo_x) || (up_cnt >= CAP_X);
  assign lo_empty = (lo_x <= '0);
  assign up_empty = (up_x >= TOP_X);
  assign lo_dec   = lower_top_r - PW'(1);
  assign up_inc   = upper_top_r + PW'(1);

  always_comb begin
    lower_top_nxt = lower_top_r;
    upper_top_nxt = upper_top_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = lower_top_r[AW-1:0];
    rd_addr       = lo_dec[AW-1:0];
    status_nxt    = ST_OK;
    unique case (act_r)
      ACT_PUSH_LO: begin
        if (lo_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = lower_top_r[AW-1:0];
          lower_top_nxt = lower_top_r + PW'(1);
        end
      end
      ACT_PUSH_HI: begin
        if (up_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = upper_top_r[AW-1:0];
          upper_top_nxt = upper_top_r - PW'(1);
        end
      end
      ACT_POP_LO: begin
        if (lo_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = lo_dec[AW-1:0];
          lower_top_nxt = lo_dec;
        end
      end
      ACT_POP_HI: begin
        if (up_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = up_inc[AW-1:0];
          upper_top_nxt = up_inc;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // shared memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.commit && rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      val_r <= in_push_value;
    end
    if (cmd.commit) begin
      res_status_r <= status_nxt;
      res_pop_r    <= rd_en;
    end
    if (cmd.load_result) begin
      out_pop_value_r <= res_pop_r ? rd_data_r : '0;
      out_status_r    <= res_status_r;
    end
  end

  // pointers and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_top_r <= '0;
      upper_top_r <= UP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        lower_top_r <= lower_top_nxt;
        upper_top_r <= upper_top_nxt;
      end
      if (cmd.load_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.slot_free   = !out_valid_r || out_ready;
  assign sts.res_refused = (res_status_r != ST_OK);

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;

  a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
    lo_x <= up_x + CW'(1))
    else $error("stack pointers crossed");

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (lo_x <= CAP_X) && (up_cnt <= CAP_X) && (lo_x >= '0))
    else $error("stack occupancy beyond capacity");

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(lower_top_r) && $stable(upper_top_r))
    else $error("pointer moved without a commit");

  a_refused_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_result && sts.res_refused) |=> out_pop_value_r == '0)
    else $error("refused request returned data");

endmodule

>>> hw/rtl/dual_stack_shared_memory_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_unit: two stacks in one shared memory
// Stack one grows up from entry 0, stack two down from entry DEPTH-1.
// ----------------------------------------------------------------------------
// Sequence: a transferred request is captured, then committed with memory access,
//   then loaded into the output register, which raises the response valid.
// Requests: the single-request sequencer takes a new request only after the
//   previous result is loaded; a stalled response holds it in its result state.
// Reset: synchronous, active low; both stacks empty, no response pending.
//   Memory contents are not cleared; a pop only reads entries pushed earlier.
module dual_stack_shared_memory_unit #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF,  // shared words, 4..4096
  parameter int CAP   = dssm_pkg::CAP_DEF     // per-stack entry limit
) (
  input logic       clk,
  input logic       rst_n,
  dssm_req_if.sink  in_req,
  dssm_rsp_if.source out_rsp
);
  import dssm_pkg::*;

  dssm_cmd_t cmd;   // sequencer commands
  dssm_sts_t sts;   // datapath status

  // Sequencer: idle -> exec -> result, one request in flight.
  dssm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: memory, pointers, full/empty checks, output register.
  // The output register decouples the response side, so a new request
  // can be taken while a finished response waits for its transfer.
  dssm_dp #(
    .DEPTH (DEPTH),
    .CAP   (CAP)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_req.action),
    .in_push_value (in_req.push_value),
    .out_valid     (out_rsp.valid),
    .out_ready     (out_rsp.ready),
    .out_pop_value (out_rsp.pop_value),
    .out_status    (out_rsp.status)
  );

endmodule
